// ===== hw/rtl/fpm_pkg.sv =====
// Package for the single-precision multiplier: field widths and types.
// No dependencies.
package fpm_pkg;
   localparam int ExpWidth  = 8;
   localparam int FracWidth = 23;
   localparam int WordWidth = 32;
   localparam int SigWidth  = FracWidth + 1;
   localparam int ProdWidth = 2 * SigWidth;
   localparam int ExpCalcWidth = ExpWidth + 2;
   localparam logic [ExpWidth-1:0] ExpOnes = {ExpWidth{1'b1}};
   localparam logic [ExpCalcWidth-1:0] ExpBias =
      ExpCalcWidth'((1 << (ExpWidth - 1)) - 1);

   typedef logic [WordWidth-1:0] word_type;
endpackage

// ===== hw/rtl/fpm_core.sv =====
// Combinational multiply datapath: classify, multiply, normalize, round, pack.
// Depends on fpm_pkg.
module fpm_core (
   input  fpm_pkg::word_type a,
   input  fpm_pkg::word_type b,
   output fpm_pkg::word_type p
);
   import fpm_pkg::*;

   logic                    sa, sb, sign;
   logic [ExpWidth-1:0]     ea, eb;
   logic [FracWidth-1:0]    fa, fb;
   logic                    za, zb, ia, ib, na, nb;
   logic [ProdWidth-1:0]    prod;
   logic [ProdWidth-1:0]    norm;
   logic [ExpCalcWidth-1:0] expo;
   logic [SigWidth:0]       kept;
   logic                    guard, sticky;
   logic [FracWidth-1:0]    frac_r;

   always_comb begin
      sa = a[FracWidth+ExpWidth];
      sb = b[FracWidth+ExpWidth];
      ea = a[FracWidth +: ExpWidth];
      eb = b[FracWidth +: ExpWidth];
      fa = a[FracWidth-1:0];
      fb = b[FracWidth-1:0];
      sign = sa ^ sb;
      za = (ea == '0);
      zb = (eb == '0);
      ia = (ea == ExpOnes) && (fa == '0);
      ib = (eb == ExpOnes) && (fb == '0);
      na = (ea == ExpOnes) && (fa != '0);
      nb = (eb == ExpOnes) && (fb != '0);
      prod = {1'b1, fa} * {1'b1, fb};
      expo = ExpCalcWidth'(ea) + ExpCalcWidth'(eb) - ExpBias;
      if (prod[ProdWidth-1]) begin
         norm = prod;
         expo = expo + 1'b1;
      end else begin
         norm = {prod[ProdWidth-2:0], 1'b0};
      end
      kept = {1'b0, norm[ProdWidth-1 -: SigWidth]};
      guard = norm[ProdWidth-1-SigWidth];
      sticky = |norm[ProdWidth-2-SigWidth:0];
      if (guard && (sticky || kept[0])) begin
         kept = kept + 1'b1;
      end
      if (kept[SigWidth]) begin
         frac_r = kept[FracWidth:1];
         expo = expo + 1'b1;
      end else begin
         frac_r = kept[FracWidth-1:0];
      end
      if (na || nb || (za && ib) || (ia && zb)) begin
         p = {sign, ExpOnes, {FracWidth{1'b1}}};
      end else if (ia || ib) begin
         p = {sign, ExpOnes, {FracWidth{1'b0}}};
      end else if (za || zb || expo[ExpCalcWidth-1] || (expo == '0)) begin
         p = {sign, {(WordWidth-1){1'b0}}};
      end else if (expo >= ExpCalcWidth'(ExpOnes)) begin
         p = {sign, ExpOnes, {FracWidth{1'b0}}};
      end else begin
         p = {sign, expo[ExpWidth-1:0], frac_r};
      end
   end
endmodule

// ===== hw/rtl/fp32_multiply_ftz_rne.sv =====
// Top level: input register, multiply datapath, output register.
// Depends on fpm_pkg and fpm_core.
// A request is registered in the input register; its product is then registered
// in the output register and offered as the response, held while rsp_stall is high.
// Throughput: one operand pair per cycle through the single-pass datapath, unless rsp_stall backs up the pipe.
// Reset: synchronous, active high; clears both stage valid flags.
module fp32_multiply_ftz_rne (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpm_pkg::word_type req_operand_a,
   input  fpm_pkg::word_type req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpm_pkg::word_type rsp_product
);
   import fpm_pkg::*;

   logic     in_vld_ff, in_vld_in, out_vld_ff, out_vld_in;
   word_type a_ff, b_ff, p_ff, p_comb;
   logic     adv_out, adv_in;

   fpm_core u_core (.a(a_ff), .b(b_ff), .p(p_comb));

   assign adv_out   = !out_vld_ff || !rsp_stall;
   assign adv_in    = !in_vld_ff || adv_out;
   assign req_stall = !adv_in;
   assign in_vld_in = adv_in ? req_valid : in_vld_ff;
   assign out_vld_in = adv_out ? in_vld_ff : out_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_product = p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         a_ff <= req_operand_a;
         b_ff <= req_operand_b;
      end
      if (adv_out) begin
         p_ff <= p_comb;
      end
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_product)))
      else $error("stalled response changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled without a full pipe");
   a_move: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !req_stall) |=> rsp_valid)
      else $error("staged item lost");
`endif
endmodule

// ===== sim/fp32_multiply_ftz_rne_test.sv =====
// Testbench for fp32_multiply_ftz_rne: directed and random operand pairs with
// bursty requests and patterned response stalls, checked against a local predictor.
// Depends on fpm_pkg and the fp32_multiply_ftz_rne RTL.
module fp32_multiply_ftz_rne_test;
   import fpm_pkg::*;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   word_type req_operand_a;
   word_type req_operand_b;
   logic     rsp_valid;
   logic     rsp_stall;
   word_type rsp_product;

   word_type expected_products[$];
   int       error_count;
   int       products_checked;
   int       burst_left;
   int       stall_mode;

   fp32_multiply_ftz_rne dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_product(rsp_product)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic word_type predict_product(word_type a, word_type b);
      logic [FracWidth-1:0]   fa, fb;
      logic [ExpWidth-1:0]    ea, eb;
      logic                   sign, za, zb, ia, ib, na, nb, guard, sticky;
      logic [ProdWidth-1:0]   full;
      logic [SigWidth:0]      kept;
      int                     expo;
      int                     cut;
      fa = a[FracWidth-1:0];
      fb = b[FracWidth-1:0];
      ea = a[FracWidth +: ExpWidth];
      eb = b[FracWidth +: ExpWidth];
      sign = a[WordWidth-1] ^ b[WordWidth-1];
      za = (ea == '0);
      zb = (eb == '0);
      ia = (ea == ExpOnes) && (fa == '0);
      ib = (eb == ExpOnes) && (fb == '0);
      na = (ea == ExpOnes) && (fa != '0);
      nb = (eb == ExpOnes) && (fb != '0);
      if (na || nb || (za && ib) || (ia && zb))
         return {sign, ExpOnes, {FracWidth{1'b1}}};
      if (ia || ib)
         return {sign, ExpOnes, {FracWidth{1'b0}}};
      if (za || zb)
         return {sign, {(WordWidth-1){1'b0}}};
      full = {{SigWidth{1'b0}}, 1'b1, fa} * {{SigWidth{1'b0}}, 1'b1, fb};
      expo = int'(ea) + int'(eb) - ((1 << (ExpWidth - 1)) - 1);
      cut = FracWidth;
      if (full[ProdWidth-1]) begin
         cut = FracWidth + 1;
         expo = expo + 1;
      end
      kept = (SigWidth + 1)'(full >> cut);
      guard = full[cut-1];
      sticky = (full & ((ProdWidth'(1) << (cut - 1)) - 1)) != '0;
      if (guard && (sticky || kept[0]))
         kept = kept + 1'b1;
      if (kept[SigWidth]) begin
         kept = kept >> 1;
         expo = expo + 1;
      end
      if (expo <= 0)
         return {sign, {(WordWidth-1){1'b0}}};
      if (expo >= (1 << ExpWidth) - 1)
         return {sign, ExpOnes, {FracWidth{1'b0}}};
      return {sign, ExpWidth'(expo), kept[FracWidth-1:0]};
   endfunction

   task automatic send_pair(word_type a, word_type b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      expected_products.push_back(predict_product(a, b));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left = burst_left - 1;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_products.size() != 0) @(posedge clock);
   endtask

   function automatic word_type random_operand();
      word_type w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0: w[30:23] = '0;
         1: w[30:23] = '1;
         2: w[22:0] = '0;
         3: w[30:23] = ExpWidth'($urandom_range(0, 20));
         4: w[30:23] = ExpWidth'($urandom_range(235, 254));
         default: w[30:23] = ExpWidth'($urandom_range(64, 190));
      endcase
      return w;
   endfunction

   task automatic test_special_values();
      word_type specials[10];
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff,
                   32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hff80_0001,
                   32'h3f80_0000, 32'hbf7f_ffff};
      foreach (specials[i]) send_pair(specials[i], specials[(i * 3 + 1) % 10]);
      send_pair(32'h7f80_0000, 32'h0000_0000);
      send_pair(32'h0040_0000, 32'hff80_0000);
      send_pair(32'hffff_ffff, 32'h3f80_0000);
   endtask

   task automatic test_rounding_edges();
      send_pair(32'h3fff_ffff, 32'h3fff_ffff);
      send_pair(32'h3f80_0001, 32'h3f80_0001);
      send_pair(32'h3fc0_0000, 32'h3fc0_0001);
      send_pair(32'h3f7f_ffff, 32'h3f80_0001);
      send_pair(32'h7f7f_ffff, 32'h7f7f_ffff);
      send_pair(32'h7f00_0000, 32'h4000_0000);
      send_pair(32'h0080_0000, 32'h3f00_0000);
      send_pair(32'h0080_0000, 32'h3f7f_ffff);
      send_pair(32'h2000_0000, 32'h1f80_0000);
      send_pair(32'h0080_0000, 32'h3f80_0000);
      drain_responses();
   endtask

   task automatic test_random_pairs();
      repeat (650) send_pair(random_operand(), random_operand());
   endtask

   initial begin
      error_count = 0;
      products_checked = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_rounding_edges();
      test_random_pairs();
      drain_responses();
      repeat (10) @(posedge clock);
      $display("Covered special values, rounding and range edges, and random pairs:");
      $display("%0d products checked under bursty requests and response stalls.",
               products_checked);
      if (error_count == 0 && expected_products.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            $error("product: unexpected transfer, actual %h", rsp_product);
            error_count = error_count + 1;
         end else begin
            if (rsp_product !== expected_products[0]) begin
               $error("product: expected %h, actual %h", expected_products[0],
                      rsp_product);
               error_count = error_count + 1;
            end
            void'(expected_products.pop_front());
            products_checked = products_checked + 1;
         end
      end
   end

   initial begin
      #200000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
